/* design/swfr_pkg.sv */
// ----------------------------------------------------------------------------
// swfr_pkg
// shared widths, command and timer codes, and the control record passed
// from the window control to the result stages
// ----------------------------------------------------------------------------
package swfr_pkg;

   localparam int CMD_W    = 2;
   localparam int ACK_W    = 3;
   localparam int TXSEQ_W  = 3;
   localparam int TIMER_W  = 2;
   localparam int DATA_W   = 64;
   localparam int DUP_W    = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

   // timer requests
   localparam logic [TIMER_W-1:0] TMR_NONE    = 2'd0;
   localparam logic [TIMER_W-1:0] TMR_START   = 2'd1;
   localparam logic [TIMER_W-1:0] TMR_STOP    = 2'd2;
   localparam logic [TIMER_W-1:0] TMR_RESTART = 2'd3;

   // duplicate acks that trigger a fast retransmit
   localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;

   typedef struct packed {
      logic                 accepted;
      logic                 tx_valid;
      logic [TXSEQ_W-1:0]   tx_seq;
      logic [TIMER_W-1:0]   timer_action;
      logic                 is_retransmit;
      logic                 window_full;
      logic                 from_store;
   } info_type;

endpackage

/* design/swfr_store.sv */
// ----------------------------------------------------------------------------
// swfr_store
// window payload memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module swfr_store #(
   parameter int DEPTH  = 4,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 2
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/swfr_ctrl.sv */
// ----------------------------------------------------------------------------
// swfr_ctrl
// window pointers, full flag and duplicate count; decides each beat's
// result and the slot access it needs
// ----------------------------------------------------------------------------
module swfr_ctrl #(
   parameter int SEQ_BITS = 3,
   parameter int WINDOW   = 4,
   parameter int SLOT_W   = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [swfr_pkg::CMD_W-1:0]    cmd,
   input  logic [swfr_pkg::ACK_W-1:0]    ack_number,
   input  logic                          ack_checksum_ok,
   output swfr_pkg::info_type            info,
   output logic                          mem_we,
   output logic [SLOT_W-1:0]             mem_waddr,
   output logic                          mem_re,
   output logic [SLOT_W-1:0]             mem_raddr
);
   import swfr_pkg::*;

   localparam int  RANGE = ((1 << SEQ_BITS) / WINDOW) * WINDOW;
   localparam bit  RZ    = (RANGE == 0);
   localparam int  CW    = (SEQ_BITS > ACK_W) ? SEQ_BITS : ACK_W;
   localparam int  XW    = CW + 8;

   logic [SEQ_BITS-1:0] base_ff, base_in;
   logic [SEQ_BITS-1:0] next_ff, next_in;
   logic [SLOT_W-1:0]   base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0]   next_slot_ff, next_slot_in;
   logic                full_ff, full_in;
   logic [DUP_W-1:0]    dup_ff, dup_in;

   logic [XW-1:0]       ack_x, base_x, next_x;
   logic [XW-1:0]       nx1_x, nx_wrap_x, bpw_x, bpw_wrap_x;
   logic [XW-1:0]       dist_x, slot_x, new_slot_x;
   logic [SLOT_W-1:0]   next_slot_inc;
   logic [DUP_W-1:0]    dup_inc;
   logic                inwin;
   info_type            info_c;
   logic                we_c, re_c;

   // sequence arithmetic
   always_comb begin
      ack_x  = XW'(ack_number);
      base_x = XW'(base_ff);
      next_x = XW'(next_ff);

      nx1_x = next_x + XW'(1);
      if (RZ || nx1_x >= XW'(RANGE)) begin
         nx_wrap_x = '0;
      end else begin
         nx_wrap_x = nx1_x;
      end

      bpw_x = base_x + XW'(WINDOW);
      if (RZ) begin
         bpw_wrap_x = '0;
      end else if (bpw_x >= XW'(RANGE)) begin
         bpw_wrap_x = bpw_x - XW'(RANGE);
      end else begin
         bpw_wrap_x = bpw_x;
      end

      // ack equal to base is never inside the window
      if (RZ || ack_x >= XW'(RANGE)) begin
         inwin = 1'b0;
      end else if (base_x <= next_x) begin
         inwin = (ack_x > base_x) && (ack_x <= next_x);
      end else begin
         inwin = (ack_x > base_x) || (ack_x <= next_x);
      end

      // slot of the new base, stepped back from the next slot
      if (next_x >= ack_x) begin
         dist_x = next_x - ack_x;
      end else begin
         dist_x = next_x + XW'(RANGE) - ack_x;
      end
      slot_x = XW'(next_slot_ff);
      if (slot_x >= dist_x) begin
         new_slot_x = slot_x - dist_x;
      end else begin
         new_slot_x = slot_x + XW'(WINDOW) - dist_x;
      end

      if (RZ || next_slot_ff == SLOT_W'(WINDOW - 1)) begin
         next_slot_inc = '0;
      end else begin
         next_slot_inc = next_slot_ff + SLOT_W'(1);
      end

      dup_inc = dup_ff + DUP_W'(1);
   end

   // per-beat decision
   always_comb begin
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      full_in      = full_ff;
      dup_in       = dup_ff;
      info_c       = '0;
      we_c         = 1'b0;
      re_c         = 1'b0;

      unique case (cmd)
         CMD_SEND: begin
            if (!full_ff) begin
               we_c                = 1'b1;
               info_c.accepted     = 1'b1;
               info_c.tx_valid     = 1'b1;
               info_c.tx_seq       = TXSEQ_W'(next_ff);
               info_c.timer_action = (base_ff == next_ff) ? TMR_START : TMR_NONE;
               next_in             = SEQ_BITS'(nx_wrap_x);
               next_slot_in        = next_slot_inc;
               if (nx_wrap_x == bpw_wrap_x) begin
                  full_in = 1'b1;
               end
            end
         end
         CMD_ACK: begin
            if (ack_checksum_ok) begin
               if (inwin) begin
                  base_in             = SEQ_BITS'(ack_x);
                  base_slot_in        = SLOT_W'(new_slot_x);
                  dup_in              = '0;
                  full_in             = 1'b0;
                  info_c.timer_action = (ack_x != next_x) ? TMR_RESTART : TMR_STOP;
               end else if (dup_inc == DUP_LIMIT) begin
                  dup_in               = '0;
                  re_c                 = 1'b1;
                  info_c.tx_valid      = 1'b1;
                  info_c.tx_seq        = TXSEQ_W'(base_ff);
                  info_c.timer_action  = TMR_RESTART;
                  info_c.is_retransmit = 1'b1;
                  info_c.from_store    = 1'b1;
               end else begin
                  dup_in = dup_inc;
               end
            end
         end
         CMD_TIMEOUT: begin
            re_c                 = 1'b1;
            info_c.tx_valid      = 1'b1;
            info_c.tx_seq        = TXSEQ_W'(base_ff);
            info_c.timer_action  = TMR_RESTART;
            info_c.is_retransmit = 1'b1;
            info_c.from_store    = 1'b1;
         end
         default: begin
         end
      endcase

      info_c.window_full = full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         full_ff      <= 1'b0;
         dup_ff       <= '0;
      end else if (step) begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         full_ff      <= full_in;
         dup_ff       <= dup_in;
      end
   end

   assign info      = info_c;
   assign mem_we    = step & we_c;
   assign mem_waddr = next_slot_ff;
   assign mem_re    = step & re_c;
   assign mem_raddr = base_slot_ff;

endmodule

/* design/sliding_window_sender_fast_retransmit_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit_unit
// sender side of a sliding window with cumulative acks, one retransmission
// timer and fast retransmit on the third duplicate ack
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per command (send, ack, timer expiry). a send
//   carries its payload, an ack its number and checksum flag
//   rsp channel: exactly one result beat per request beat, in order: send
//   accepted or refused, the packet to transmit (if any), timer request and
//   the window full flag after the update
//   path: each request beat passes the read stage, where the registered read
//   of the payload memory lands, and then the output register
//   throughput: one beat per cycle while rsp_ready is high; pointers live in
//   registers and each beat makes at most one access to the payload memory,
//   so beats follow back to back with no interlock
//   stall: while rsp_ready is low the output register holds its beat and one
//   more request beat is taken into the read stage; then req_ready drops
//   reset: pointers, full flag and duplicate count clear, both stages empty;
//   payload slots are undefined until a send writes them
// ----------------------------------------------------------------------------
module sliding_window_sender_fast_retransmit_unit #(
   parameter int SEQ_BITS     = 3,
   parameter int WINDOW       = 4,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [swfr_pkg::CMD_W-1:0]     req_cmd,
   input  logic [swfr_pkg::DATA_W-1:0]    req_payload_word,
   input  logic [swfr_pkg::ACK_W-1:0]     req_ack_number,
   input  logic                           req_ack_checksum_ok,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic                           rsp_tx_valid,
   output logic [swfr_pkg::TXSEQ_W-1:0]   rsp_tx_seq,
   output logic [swfr_pkg::DATA_W-1:0]    rsp_tx_payload,
   output logic [swfr_pkg::TIMER_W-1:0]   rsp_timer_action,
   output logic                           rsp_is_retransmit,
   output logic                           rsp_window_full
);
   import swfr_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   // request handshake and stage movement
   logic                    step;
   logic                    s1_advance;
   logic                    s1_valid_ff;
   info_type                s1_info_ff;
   logic [PAYLOAD_BITS-1:0] s1_data_ff;
   logic                    out_valid_ff;
   info_type                out_info_ff;
   logic [DATA_W-1:0]       out_payload_ff, out_payload_in;

   // control and memory
   info_type                info;
   logic                    mem_we, mem_re;
   logic [SLOT_W-1:0]       mem_waddr, mem_raddr;
   logic [PAYLOAD_BITS-1:0] send_data;
   logic [PAYLOAD_BITS-1:0] rd_data;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign step       = req_valid && req_ready;
   assign send_data  = PAYLOAD_BITS'(req_payload_word);

   swfr_ctrl #(
      .SEQ_BITS (SEQ_BITS),
      .WINDOW   (WINDOW),
      .SLOT_W   (SLOT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .cmd             (req_cmd),
      .ack_number      (req_ack_number),
      .ack_checksum_ok (req_ack_checksum_ok),
      .info            (info),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr)
   );

   // payload of each slot; read data lands with the beat in the read stage
   swfr_store #(
      .DEPTH  (WINDOW),
      .WIDTH  (PAYLOAD_BITS),
      .ADDR_W (SLOT_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (send_data),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   // retransmits take the stored slot, fresh sends their own word, other beats zero
   always_comb begin
      if (!s1_info_ff.tx_valid) begin
         out_payload_in = '0;
      end else if (s1_info_ff.from_store) begin
         out_payload_in = DATA_W'(rd_data);
      end else begin
         out_payload_in = DATA_W'(s1_data_ff);
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (step) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_info_ff <= info;
         s1_data_ff <= send_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_info_ff    <= s1_info_ff;
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_accepted      = out_info_ff.accepted;
   assign rsp_tx_valid      = out_info_ff.tx_valid;
   assign rsp_tx_seq        = out_info_ff.tx_seq;
   assign rsp_tx_payload    = out_payload_ff;
   assign rsp_timer_action  = out_info_ff.timer_action;
   assign rsp_is_retransmit = out_info_ff.is_retransmit;
   assign rsp_window_full   = out_info_ff.window_full;

endmodule
